// ===== hdl/sliding_window_median_filter_core_defines.svh =====
// Assertion macros used by the median filter back end.
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_CORE_DEFINES_SVH

// same-cycle implication
`define SWMF_ASSERT_IMP(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (pre) |-> (post)) \
    else $error("swmf assertion failed");

// next-cycle implication
`define SWMF_ASSERT_NXT(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (pre) |=> (post)) \
    else $error("swmf assertion failed");

`endif

// ===== hdl/swmf_pkg.sv =====
// Types, constants and helpers of the sliding window median filter.
package swmf_pkg;

  localparam int MAX_MASK    = 7;
  localparam int MAX_WIDTH   = 2048;
  localparam int PIXEL_BITS  = 16;

  localparam int DATA_W      = 16;
  localparam int MASK_W      = 3;
  localparam int WID_W       = 12;
  localparam int HGT_W       = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int LINE_W      = $clog2(MAX_MASK);
  localparam int MSZ_W       = $clog2(MAX_MASK + 1);
  localparam int STORE_DEPTH = MAX_MASK * MAX_WIDTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int NCELL       = MAX_MASK * MAX_MASK;
  localparam int CNT_W       = $clog2(NCELL + 1);
  localparam int IDX_W       = $clog2(NCELL);
  localparam int Q_DEPTH     = 4;
  localparam int QPTR_W      = $clog2(Q_DEPTH);

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASK_ROWS    = 2'd0,
    REG_MASK_COLS    = 2'd1,
    REG_IMAGE_WIDTH  = 2'd2,
    REG_IMAGE_HEIGHT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [MSZ_W-1:0]  rows;
    logic [MSZ_W-1:0]  cols;
    logic [COL_W-1:0]  wm1;     // width - 1
    logic [HGT_W-1:0]  hmax;    // height - 1
    logic [MSZ_W-1:0]  hr;
    logic [MSZ_W-1:0]  hc;
    logic [MSZ_W-1:0]  rowlag;
    logic [MSZ_W-1:0]  collag;
    logic [CNT_W-1:0]  win_n;
    logic [IDX_W-1:0]  mid;
  } cfg_t;

  // queue entry: a line store write or one output job
  typedef struct packed {
    logic                  is_job;
    logic                  frame_last;
    logic                  run_last;
    logic [HGT_W-1:0]      row;
    logic [LINE_W-1:0]     line;
    logic [COL_W-1:0]      col;
    logic [PIXEL_BITS-1:0] pix;
  } task_t;

  function automatic logic [LINE_W-1:0] next_line(input logic [LINE_W-1:0] l);
    next_line = (l == LINE_W'(MAX_MASK - 1)) ? '0 : l + LINE_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [LINE_W-1:0] l,
                                                   input logic [COL_W-1:0] c);
    store_addr = ADDR_W'(l) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
  endfunction

endpackage

// ===== hdl/swmf_ram.sv =====
// Generic single-write, registered-read RAM.
module swmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/swmf_queue.sv =====
// Short task queue between front and back.
module swmf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  swmf_pkg::task_t push_data,
  input  logic            pop,
  output swmf_pkg::task_t pop_data,
  output logic            full,
  output logic            empty
);

  swmf_pkg::task_t                    mem_r [swmf_pkg::Q_DEPTH];
  logic [swmf_pkg::QPTR_W-1:0]        wp_r, rp_r;
  logic [swmf_pkg::QPTR_W:0]          cnt_r;

  assign full     = (cnt_r == (swmf_pkg::QPTR_W + 1)'(swmf_pkg::Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== hdl/swmf_front.sv =====
// Front end: accepts requests, tracks positions, queues writes and jobs.
module swmf_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            restart_i,
  input  swmf_pkg::cfg_t                  cfg_i,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [swmf_pkg::DATA_W-1:0]     in_tdata,
  input  logic                            in_tuser,
  output logic                            push_o,
  output swmf_pkg::task_t                 push_data_o,
  input  logic                            q_full_i
);

  typedef enum logic {F_IDLE, F_EMIT} fstate_t;

  fstate_t                          state_r, state_nxt;
  logic [swmf_pkg::HGT_W-1:0]       in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [swmf_pkg::COL_W-1:0]       in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [swmf_pkg::LINE_W-1:0]      in_line_r, in_line_nxt, out_line_r, out_line_nxt;
  logic [swmf_pkg::COL_W-1:0]       pc_r, pc_nxt;

  logic accept, full, last_pos, start_ok, more;
  swmf_pkg::task_t job;

  function automatic logic need_ok(input logic [swmf_pkg::COL_W-1:0] col,
                                   input logic [swmf_pkg::COL_W-1:0] pc,
                                   input logic [swmf_pkg::MSZ_W-1:0] lag,
                                   input logic [swmf_pkg::COL_W-1:0] wm1);
    logic [swmf_pkg::COL_W:0] s;
    s = {1'b0, col} + (swmf_pkg::COL_W + 1)'(lag);
    need_ok = (s > {1'b0, wm1}) ? (wm1 <= pc) : (s[swmf_pkg::COL_W-1:0] <= pc);
  endfunction

  assign in_tready = (state_r == F_IDLE) && !q_full_i;
  assign accept    = in_tvalid && in_tready;
  assign full      = (in_row_r > cfg_i.hmax);
  assign last_pos  = (out_row_r == cfg_i.hmax) && (out_col_r == cfg_i.wm1);
  assign start_ok  = (in_row_r >= swmf_pkg::HGT_W'(cfg_i.rowlag)) &&
                     (out_row_r == in_row_r - swmf_pkg::HGT_W'(cfg_i.rowlag)) &&
                     need_ok(out_col_r, in_col_r, cfg_i.collag, cfg_i.wm1);
  assign more      = !last_pos && (out_col_r != cfg_i.wm1) &&
                     need_ok(out_col_r + 1'b1, pc_r, cfg_i.collag, cfg_i.wm1);

  always_comb begin
    job            = '0;
    job.is_job     = 1'b1;
    job.frame_last = last_pos;
    job.row        = out_row_r;
    job.line       = out_line_r;
    job.col        = out_col_r;
    job.run_last   = (state_r == F_IDLE) ? 1'b1 : !more;
  end

  always_comb begin
    push_o      = 1'b0;
    push_data_o = job;
    if (state_r == F_IDLE) begin
      if (accept && (in_tuser == swmf_pkg::KIND_PIXEL) && !full) begin
        push_o             = 1'b1;
        push_data_o        = '0;
        push_data_o.line   = in_line_r;
        push_data_o.col    = in_col_r;
        push_data_o.pix    = in_tdata[swmf_pkg::PIXEL_BITS-1:0];
      end else if (accept && (in_tuser == swmf_pkg::KIND_DRAIN) && full) begin
        push_o = 1'b1;
      end
    end else begin
      push_o = !q_full_i;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_row_nxt   = in_row_r;
    in_col_nxt   = in_col_r;
    in_line_nxt  = in_line_r;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    out_line_nxt = out_line_r;
    pc_nxt       = pc_r;
    if (restart_i) begin
      state_nxt    = F_IDLE;
      in_row_nxt   = '0;
      in_col_nxt   = '0;
      in_line_nxt  = '0;
      out_row_nxt  = '0;
      out_col_nxt  = '0;
      out_line_nxt = '0;
    end else begin
      if (state_r == F_IDLE && accept && (in_tuser == swmf_pkg::KIND_PIXEL) && !full) begin
        if (in_col_r == cfg_i.wm1) begin
          in_col_nxt  = '0;
          in_row_nxt  = in_row_r + 1'b1;
          in_line_nxt = swmf_pkg::next_line(in_line_r);
        end else begin
          in_col_nxt = in_col_r + 1'b1;
        end
        if (start_ok) begin
          state_nxt = F_EMIT;
          pc_nxt    = in_col_r;
        end
      end
      if (push_o && (state_r == F_EMIT || in_tuser == swmf_pkg::KIND_DRAIN)) begin
        if (last_pos) begin
          in_row_nxt   = '0;
          in_col_nxt   = '0;
          in_line_nxt  = '0;
          out_row_nxt  = '0;
          out_col_nxt  = '0;
          out_line_nxt = '0;
        end else if (out_col_r == cfg_i.wm1) begin
          out_col_nxt  = '0;
          out_row_nxt  = out_row_r + 1'b1;
          out_line_nxt = swmf_pkg::next_line(out_line_r);
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
        if (state_r == F_EMIT && !more) begin
          state_nxt = F_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_line_r  <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_line_r <= '0;
      pc_r       <= '0;
    end else begin
      state_r    <= state_nxt;
      in_row_r   <= in_row_nxt;
      in_col_r   <= in_col_nxt;
      in_line_r  <= in_line_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
      out_line_r <= out_line_nxt;
      pc_r       <= pc_nxt;
    end
  end

endmodule

// ===== hdl/swmf_back.sv =====
// Back end: line store, window fetch, insertion sorter and result register.
`include "sliding_window_median_filter_core_defines.svh"

module swmf_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  swmf_pkg::cfg_t              cfg_i,
  input  logic                        q_empty_i,
  input  swmf_pkg::task_t             q_data_i,
  output logic                        q_pop_o,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [swmf_pkg::DATA_W-1:0] out_tdata,
  output logic                        out_tlast,
  output logic                        out_tuser
);

  typedef enum logic [1:0] {B_IDLE, B_RUN, B_FLUSH, B_OUT} bstate_t;

  localparam int RR_W = swmf_pkg::HGT_W + 1;
  localparam int CB_W = swmf_pkg::COL_W + 2;

  bstate_t                            state_r, state_nxt;
  logic [swmf_pkg::MSZ_W-1:0]         a_r, a_nxt, b_r, b_nxt;
  logic signed [RR_W-1:0]             rr_r, rr_nxt, rs, rr1;
  logic signed [CB_W-1:0]             colb_r, colb_nxt, cc_raw;
  logic signed [swmf_pkg::LINE_W+1:0] ls;
  logic [swmf_pkg::LINE_W-1:0]        cline_r, cline_nxt;
  logic [swmf_pkg::COL_W-1:0]         cc;
  logic                               fl_r, fl_nxt, rl_r, rl_nxt;
  logic                               ins_vld_r, rd_issue, ram_we, out_ld;
  logic [swmf_pkg::CNT_W-1:0]         n_r, n_nxt;
  logic [swmf_pkg::PIXEL_BITS-1:0]    sort_r [swmf_pkg::NCELL];
  logic [swmf_pkg::PIXEL_BITS-1:0]    sort_nxt [swmf_pkg::NCELL];
  logic                               keep [swmf_pkg::NCELL];
  logic [swmf_pkg::PIXEL_BITS-1:0]    rdata;
  logic [swmf_pkg::ADDR_W-1:0]        raddr, waddr;
  logic                               out_vld_r;
  logic [swmf_pkg::DATA_W-1:0]        out_data_r;
  logic                               out_last_r, out_user_r;

  assign q_pop_o  = (state_r == B_IDLE) && !q_empty_i;
  assign ram_we   = q_pop_o && !q_data_i.is_job;
  assign rd_issue = (state_r == B_RUN);
  assign waddr    = swmf_pkg::store_addr(q_data_i.line, q_data_i.col);

  // clamped column of the current tap
  assign cc_raw = colb_r + CB_W'(b_r);
  always_comb begin
    if (cc_raw < 0) begin
      cc = '0;
    end else if (cc_raw > $signed({2'b00, cfg_i.wm1})) begin
      cc = cfg_i.wm1;
    end else begin
      cc = cc_raw[swmf_pkg::COL_W-1:0];
    end
  end
  assign raddr = swmf_pkg::store_addr(cline_r, cc);

  swmf_ram #(
    .WIDTH (swmf_pkg::PIXEL_BITS),
    .DEPTH (swmf_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (q_data_i.pix),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rs  = $signed({1'b0, q_data_i.row}) - RR_W'(cfg_i.hr);
  assign ls  = $signed({2'b00, q_data_i.line}) - (swmf_pkg::LINE_W + 2)'(cfg_i.hr);
  assign rr1 = rr_r + RR_W'(1);

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    rr_nxt    = rr_r;
    colb_nxt  = colb_r;
    cline_nxt = cline_r;
    fl_nxt    = fl_r;
    rl_nxt    = rl_r;
    case (state_r)
      B_IDLE: begin
        if (q_pop_o && q_data_i.is_job) begin
          state_nxt = B_RUN;
          a_nxt     = '0;
          b_nxt     = '0;
          rr_nxt    = rs;
          colb_nxt  = $signed({2'b00, q_data_i.col}) - CB_W'(cfg_i.hc);
          fl_nxt    = q_data_i.frame_last;
          rl_nxt    = q_data_i.run_last;
          if (rs < 0) begin
            cline_nxt = '0;
          end else if (ls < 0) begin
            cline_nxt = swmf_pkg::LINE_W'(ls + (swmf_pkg::LINE_W + 2)'(swmf_pkg::MAX_MASK));
          end else begin
            cline_nxt = swmf_pkg::LINE_W'(ls);
          end
        end
      end
      B_RUN: begin
        if (b_r == cfg_i.cols - 1'b1) begin
          b_nxt  = '0;
          a_nxt  = a_r + 1'b1;
          rr_nxt = rr1;
          if (rr1 >= 1 && rr1 <= $signed({1'b0, cfg_i.hmax})) begin
            cline_nxt = swmf_pkg::next_line(cline_r);
          end
          if (a_r == cfg_i.rows - 1'b1) begin
            state_nxt = B_FLUSH;
          end
        end else begin
          b_nxt = b_r + 1'b1;
        end
      end
      B_FLUSH: state_nxt = B_OUT;
      B_OUT: begin
        if (out_ld) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // insertion sorter: each cell keeps, takes the new value or shifts up
  always_comb begin
    for (int i = 0; i < swmf_pkg::NCELL; i++) begin
      keep[i] = (swmf_pkg::CNT_W'(i) < n_r) && (sort_r[i] <= rdata);
    end
    for (int i = 0; i < swmf_pkg::NCELL; i++) begin
      if (keep[i]) begin
        sort_nxt[i] = sort_r[i];
      end else if (i == 0) begin
        sort_nxt[i] = rdata;
      end else if (keep[i-1]) begin
        sort_nxt[i] = rdata;
      end else begin
        sort_nxt[i] = sort_r[i-1];
      end
    end
    if (state_r == B_IDLE) begin
      n_nxt = '0;
    end else if (ins_vld_r) begin
      n_nxt = n_r + 1'b1;
    end else begin
      n_nxt = n_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ins_vld_r) begin
      for (int i = 0; i < swmf_pkg::NCELL; i++) begin
        sort_r[i] <= sort_nxt[i];
      end
    end
  end

  assign out_ld = (state_r == B_OUT) && (!out_vld_r || out_tready);

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_data_r <= swmf_pkg::DATA_W'(sort_r[cfg_i.mid]);
      out_last_r <= rl_r;
      out_user_r <= fl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      a_r       <= '0;
      b_r       <= '0;
      rr_r      <= '0;
      colb_r    <= '0;
      cline_r   <= '0;
      fl_r      <= 1'b0;
      rl_r      <= 1'b0;
      n_r       <= '0;
      ins_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      a_r       <= a_nxt;
      b_r       <= b_nxt;
      rr_r      <= rr_nxt;
      colb_r    <= colb_nxt;
      cline_r   <= cline_nxt;
      fl_r      <= fl_nxt;
      rl_r      <= rl_nxt;
      n_r       <= n_nxt;
      ins_vld_r <= rd_issue;
      if (out_ld) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  `SWMF_ASSERT_IMP(a_full_window, clk, rst_n, (state_r == B_OUT), (n_r == cfg_i.win_n))
  `SWMF_ASSERT_NXT(a_flush_fill, clk, rst_n, (state_r == B_FLUSH), (n_r == cfg_i.win_n))
  `SWMF_ASSERT_IMP(a_no_rw_clash, clk, rst_n, ram_we, (!rd_issue && !ins_vld_r))

endmodule

// ===== hdl/sliding_window_median_filter_core.sv =====
// Top level of the streaming 2-D median filter with replicated borders.
//
// Usage:
//   in_*  : request stream, tdata = pixel_value, tuser = kind (0 pixel,
//           1 drain). Pixels of one frame arrive in raster order; after the
//           last pixel, drain requests pull out the trailing outputs.
//   out_* : results in raster order, tdata = median_value, tlast = last
//           result of the causing request, tuser = frame end.
//   cfg_* : register write port (mask rows, mask cols, width, height);
//           write only while idle. Any write restarts the frame.
// Flow: the front end accepts a request only while idle and the queue has
// room, then queues the outputs it completes; the back end works on one
// output at a time, reading its rows*cols taps through the single read port
// of the line store feeding the insertion sorter. The task queue lets the
// front end keep accepting while the back end works. A job passes the task
// queue, the window fetch, the flush and output states and the result register.
// Reset (synchronous, rst_n low) clears all positions and loads the default
// geometry; the line store is not cleared. A stalled receiver holds the
// result register, then the queue fills and in_tready drops.
module sliding_window_median_filter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [swmf_pkg::DATA_W-1:0]    in_tdata,   // [15:0] pixel_value
  input  logic                           in_tuser,   // [0] kind
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [swmf_pkg::DATA_W-1:0]    out_tdata,  // [15:0] median_value
  output logic                           out_tlast,
  output logic                           out_tuser,  // [0] frame_end
  input  logic                           cfg_we,
  input  logic [swmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swmf_pkg::CFG_W-1:0]     cfg_data
);

  logic [swmf_pkg::MSZ_W-1:0] rows_r, cols_r;
  logic [swmf_pkg::COL_W-1:0] wm1_r;
  logic [swmf_pkg::HGT_W-1:0] hmax_r;
  logic [swmf_pkg::WID_W-1:0] wv;
  logic [swmf_pkg::HGT_W-1:0] hv;
  swmf_pkg::cfg_t             cfg;
  logic                       push, pop, q_full, q_empty;
  swmf_pkg::task_t            push_data, pop_data;
  logic [2*swmf_pkg::MSZ_W-1:0] area;

  function automatic logic [swmf_pkg::MSZ_W-1:0] clamp_mask(
      input logic [swmf_pkg::MASK_W-1:0] v);
    if (v == '0) begin
      clamp_mask = swmf_pkg::MSZ_W'(1);
    end else if (int'(v) > swmf_pkg::MAX_MASK) begin
      clamp_mask = swmf_pkg::MSZ_W'(swmf_pkg::MAX_MASK);
    end else begin
      clamp_mask = swmf_pkg::MSZ_W'(v);
    end
  endfunction

  assign wv = cfg_data[swmf_pkg::WID_W-1:0];
  assign hv = cfg_data[swmf_pkg::HGT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= swmf_pkg::MSZ_W'(3);
      cols_r <= swmf_pkg::MSZ_W'(3);
      wm1_r  <= swmf_pkg::COL_W'(swmf_pkg::MAX_WIDTH - 1);
      hmax_r <= swmf_pkg::HGT_W'(1023);
    end else if (cfg_we) begin
      case (swmf_pkg::reg_idx_t'(cfg_index))
        swmf_pkg::REG_MASK_ROWS: rows_r <= clamp_mask(cfg_data[swmf_pkg::MASK_W-1:0]);
        swmf_pkg::REG_MASK_COLS: cols_r <= clamp_mask(cfg_data[swmf_pkg::MASK_W-1:0]);
        swmf_pkg::REG_IMAGE_WIDTH: begin
          if (wv == '0) begin
            wm1_r <= '0;
          end else if (int'(wv) > swmf_pkg::MAX_WIDTH) begin
            wm1_r <= swmf_pkg::COL_W'(swmf_pkg::MAX_WIDTH - 1);
          end else begin
            wm1_r <= swmf_pkg::COL_W'(wv - 1'b1);
          end
        end
        swmf_pkg::REG_IMAGE_HEIGHT: hmax_r <= (hv == '0) ? '0 : hv - 1'b1;
        default: rows_r <= rows_r;
      endcase
    end
  end

  assign area = rows_r * cols_r;

  always_comb begin
    cfg        = '0;
    cfg.rows   = rows_r;
    cfg.cols   = cols_r;
    cfg.wm1    = wm1_r;
    cfg.hmax   = hmax_r;
    cfg.hr     = rows_r >> 1;
    cfg.hc     = cols_r >> 1;
    cfg.rowlag = rows_r - 1'b1 - (rows_r >> 1);
    cfg.collag = cols_r - 1'b1 - (cols_r >> 1);
    cfg.win_n  = swmf_pkg::CNT_W'(area);
    cfg.mid    = swmf_pkg::IDX_W'(area >> 1);
  end

  swmf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart_i   (cfg_we),
    .cfg_i       (cfg),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .push_o      (push),
    .push_data_o (push_data),
    .q_full_i    (q_full)
  );

  swmf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  swmf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg),
    .q_empty_i  (q_empty),
    .q_data_i   (pop_data),
    .q_pop_o    (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
